// ===== rtl/i2cra_pkg.sv =====
// Package for the I2C single-register access master.
// Holds the command, error and sequence codes and the register reset value.
// Depends on nothing; the top level i2c_master_register_access uses it.
package i2cra_pkg;

  // Command codes carried by the operation field.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Error codes reported with each result word.
  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_BUS_BUSY = 2'd1,
    ERR_NO_ACK   = 2'd2
  } err_e;

  // Steps of a transaction.
  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_START     = 5'd1,
    ST_SEND_AW   = 5'd2,
    ST_ACK_AW    = 5'd3,
    ST_SEND_REG  = 5'd4,
    ST_ACK_REG   = 5'd5,
    ST_SEND_DATA = 5'd6,
    ST_ACK_DATA  = 5'd7,
    ST_RESTART   = 5'd8,
    ST_SEND_AR   = 5'd9,
    ST_ACK_AR    = 5'd10,
    ST_READ      = 5'd11,
    ST_NACK      = 5'd12,
    ST_STOP      = 5'd13
  } step_e;

  // Acknowledge timeout after reset, in SDA samples.
  localparam logic [7:0] AckTimeoutReset = 8'd250;

  // Last bit index of a byte.
  localparam logic [2:0] LastBit = 3'd7;

endpackage

// ===== rtl/i2cra_cmd_if.sv =====
// Command channel of the I2C single-register access master.
// Carries valid, ready and one command or tick word; uses no package.
interface i2cra_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [6:0] device_address;
  logic [7:0] register_address;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (
    output valid, operation, device_address, register_address, write_data, sda_in,
    input  ready
  );

  modport sink (
    input  valid, operation, device_address, register_address, write_data, sda_in,
    output ready
  );
endinterface

// ===== rtl/i2cra_res_if.sv =====
// Result channel of the I2C single-register access master.
// Carries valid, ready and one result word; uses no package.
interface i2cra_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [1:0] error_code;
  logic [7:0] read_data;

  modport source (
    output valid, scl_out, sda_out, busy_res, done_res, error_code, read_data,
    input  ready
  );

  modport sink (
    input  valid, scl_out, sda_out, busy_res, done_res, error_code, read_data,
    output ready
  );
endinterface

// ===== rtl/i2c_master_register_access.sv =====
// Top level of the I2C single-register access master.
// Depends on i2cra_pkg, i2cra_cmd_if and i2cra_res_if.
//
// Usage
// The command channel takes one word at a time: a register write or read
// command, or a quarter-bit tick that carries the sampled SDA level. Each
// accepted word gives exactly one result word on the result channel, with
// the SCL and SDA drive levels, busy, a done pulse, the latched error code
// and the byte of the last completed read.
// A command arriving while a transaction runs is ignored; a tick while idle
// leaves both lines released. The user must write the ack_timeout register
// via cfg_we_i and cfg_wdata_i only while idle; the block does not enforce it.
// The result of a word is on the result channel in the cycle after it is
// accepted, through the single result register stage. One word is accepted
// per cycle while the result register is empty or its word is being taken.
// When the receiver stalls, the result register holds its word and ready
// stays high only if that word is taken in the same cycle.
// Reset releases the sequencer's line levels, returns it to idle, clears its
// error code and read byte and loads an acknowledge timeout of 250 samples.
module i2c_master_register_access (
  input  logic               clk_i,
  input  logic               rst_ni,
  i2cra_cmd_if.sink          cmd_i,
  i2cra_res_if.source        res_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i
);

  // Sequencer state.
  i2cra_pkg::step_e step_q, step_d;
  logic [1:0] phase_q, phase_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] wait_q, wait_d;
  logic [6:0] dev_q, dev_d;
  logic [7:0] reg_q, reg_d;
  logic [7:0] data_q, data_d;
  logic       read_q, read_d;
  logic [7:0] rx_q, rx_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  i2cra_pkg::err_e err_q, err_d;
  logic [7:0] timeout_q;
  logic       done;

  // Result register.
  logic       out_valid_q;
  logic       out_scl_q;
  logic       out_sda_q;
  logic       out_busy_q;
  logic       out_done_q;
  logic [1:0] out_err_q;
  logic [7:0] out_rx_q;

  logic accept;
  i2cra_pkg::op_e op;

  assign op          = i2cra_pkg::op_e'(cmd_i.operation);
  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  // Next state and result for one accepted word.
  always_comb begin
    step_d  = step_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    wait_d  = wait_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    data_d  = data_q;
    read_d  = read_q;
    rx_d    = rx_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    err_d   = err_q;
    done    = 1'b0;

    if (step_q == i2cra_pkg::ST_IDLE) begin
      if (op == i2cra_pkg::OP_WRITE || op == i2cra_pkg::OP_READ) begin
        dev_d   = cmd_i.device_address;
        reg_d   = cmd_i.register_address;
        data_d  = cmd_i.write_data;
        read_d  = (op == i2cra_pkg::OP_READ);
        err_d   = i2cra_pkg::ERR_OK;
        step_d  = i2cra_pkg::ST_START;
        shift_d = 8'd0;
        bit_d   = 3'd0;
        wait_d  = 8'd0;
        phase_d = 2'd0;
      end else begin
        scl_d = 1'b1;
        sda_d = 1'b1;
      end
    end else if (op == i2cra_pkg::OP_TICK) begin
      // Phase advances by default; the early exits below override it.
      phase_d = phase_q + 2'd1;
      case (step_q)
        i2cra_pkg::ST_START: begin
          case (phase_q)
            2'd0: begin
              sda_d = 1'b1;
              scl_d = 1'b1;
            end
            2'd1: begin
              if (!cmd_i.sda_in) begin
                // Bus held low by another device: give up at once.
                err_d   = i2cra_pkg::ERR_BUS_BUSY;
                step_d  = i2cra_pkg::ST_IDLE;
                shift_d = 8'd0;
                bit_d   = 3'd0;
                wait_d  = 8'd0;
                phase_d = 2'd0;
                scl_d   = 1'b1;
                sda_d   = 1'b1;
                done    = 1'b1;
              end else begin
                sda_d = 1'b0;
              end
            end
            2'd2: scl_d = 1'b0;
            default: begin
              step_d  = i2cra_pkg::ST_SEND_AW;
              shift_d = {dev_q, 1'b0};
              bit_d   = 3'd0;
              wait_d  = 8'd0;
            end
          endcase
        end
        i2cra_pkg::ST_SEND_AW, i2cra_pkg::ST_SEND_REG,
        i2cra_pkg::ST_SEND_DATA, i2cra_pkg::ST_SEND_AR: begin
          case (phase_q)
            2'd0: sda_d = shift_q[7];
            2'd1: scl_d = 1'b1;
            2'd2: ;
            default: begin
              scl_d   = 1'b0;
              shift_d = {shift_q[6:0], 1'b0};
              if (bit_q == i2cra_pkg::LastBit) begin
                // Each send step is followed by its acknowledge step.
                case (step_q)
                  i2cra_pkg::ST_SEND_AW:   step_d = i2cra_pkg::ST_ACK_AW;
                  i2cra_pkg::ST_SEND_REG:  step_d = i2cra_pkg::ST_ACK_REG;
                  i2cra_pkg::ST_SEND_DATA: step_d = i2cra_pkg::ST_ACK_DATA;
                  default:                 step_d = i2cra_pkg::ST_ACK_AR;
                endcase
                shift_d = 8'd0;
                bit_d   = 3'd0;
                wait_d  = 8'd0;
              end else begin
                bit_d = bit_q + 3'd1;
              end
            end
          endcase
        end
        i2cra_pkg::ST_ACK_AW, i2cra_pkg::ST_ACK_REG,
        i2cra_pkg::ST_ACK_DATA, i2cra_pkg::ST_ACK_AR: begin
          case (phase_q)
            2'd0: begin
              sda_d  = 1'b1;
              wait_d = 8'd0;
            end
            2'd1: scl_d = 1'b1;
            2'd2: begin
              if (cmd_i.sda_in) begin
                if (wait_q >= timeout_q) begin
                  // No acknowledge in time: finish with a stop.
                  err_d   = i2cra_pkg::ERR_NO_ACK;
                  step_d  = i2cra_pkg::ST_STOP;
                  shift_d = 8'd0;
                  bit_d   = 3'd0;
                  wait_d  = 8'd0;
                  phase_d = 2'd0;
                end else begin
                  // Stay in this phase and sample again on the next tick.
                  wait_d  = wait_q + 8'd1;
                  phase_d = phase_q;
                end
              end
            end
            default: begin
              scl_d  = 1'b0;
              bit_d  = 3'd0;
              wait_d = 8'd0;
              case (step_q)
                i2cra_pkg::ST_ACK_AW: begin
                  step_d  = i2cra_pkg::ST_SEND_REG;
                  shift_d = reg_q;
                end
                i2cra_pkg::ST_ACK_REG: begin
                  step_d  = read_q ? i2cra_pkg::ST_RESTART : i2cra_pkg::ST_SEND_DATA;
                  shift_d = read_q ? 8'd0 : data_q;
                end
                i2cra_pkg::ST_ACK_DATA: begin
                  step_d  = i2cra_pkg::ST_STOP;
                  shift_d = 8'd0;
                end
                default: begin
                  step_d  = i2cra_pkg::ST_READ;
                  shift_d = 8'd0;
                end
              endcase
            end
          endcase
        end
        i2cra_pkg::ST_RESTART: begin
          case (phase_q)
            2'd0: sda_d = 1'b1;
            2'd1: scl_d = 1'b1;
            2'd2: sda_d = 1'b0;
            default: begin
              scl_d   = 1'b0;
              step_d  = i2cra_pkg::ST_SEND_AR;
              shift_d = {dev_q, 1'b1};
              bit_d   = 3'd0;
              wait_d  = 8'd0;
            end
          endcase
        end
        i2cra_pkg::ST_READ: begin
          case (phase_q)
            2'd0: sda_d = 1'b1;
            2'd1: scl_d = 1'b1;
            2'd2: shift_d = {shift_q[6:0], cmd_i.sda_in};
            default: begin
              scl_d = 1'b0;
              if (bit_q == i2cra_pkg::LastBit) begin
                rx_d    = shift_q;
                step_d  = i2cra_pkg::ST_NACK;
                shift_d = 8'd0;
                bit_d   = 3'd0;
                wait_d  = 8'd0;
              end else begin
                bit_d = bit_q + 3'd1;
              end
            end
          endcase
        end
        i2cra_pkg::ST_NACK: begin
          case (phase_q)
            2'd0: sda_d = 1'b1;
            2'd1: scl_d = 1'b1;
            2'd2: ;
            default: begin
              scl_d   = 1'b0;
              step_d  = i2cra_pkg::ST_STOP;
              shift_d = 8'd0;
              bit_d   = 3'd0;
              wait_d  = 8'd0;
            end
          endcase
        end
        i2cra_pkg::ST_STOP: begin
          case (phase_q)
            2'd0: scl_d = 1'b0;
            2'd1: sda_d = 1'b0;
            2'd2: scl_d = 1'b1;
            default: begin
              step_d  = i2cra_pkg::ST_IDLE;
              shift_d = 8'd0;
              bit_d   = 3'd0;
              wait_d  = 8'd0;
              phase_d = 2'd0;
              scl_d   = 1'b1;
              sda_d   = 1'b1;
              done    = 1'b1;
            end
          endcase
        end
        default: begin
          // Codes outside the sequence fall back to idle.
          step_d  = i2cra_pkg::ST_IDLE;
          shift_d = 8'd0;
          bit_d   = 3'd0;
          wait_d  = 8'd0;
          phase_d = 2'd0;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
        end
      endcase
    end
  end

  // Sequencer state registers, updated on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= i2cra_pkg::ST_IDLE;
      phase_q <= 2'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      wait_q  <= 8'd0;
      dev_q   <= 7'd0;
      reg_q   <= 8'd0;
      data_q  <= 8'd0;
      read_q  <= 1'b0;
      rx_q    <= 8'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      err_q   <= i2cra_pkg::ERR_OK;
    end else if (accept) begin
      step_q  <= step_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      data_q  <= data_d;
      read_q  <= read_d;
      rx_q    <= rx_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      err_q   <= err_d;
    end
  end

  // Acknowledge timeout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= i2cra_pkg::AckTimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Result valid flag: set by an accepted word, cleared when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_scl_q  <= scl_d;
      out_sda_q  <= sda_d;
      out_busy_q <= (step_d != i2cra_pkg::ST_IDLE);
      out_done_q <= done;
      out_err_q  <= err_d;
      out_rx_q   <= rx_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.scl_out    = out_scl_q;
  assign res_o.sda_out    = out_sda_q;
  assign res_o.busy_res   = out_busy_q;
  assign res_o.done_res   = out_done_q;
  assign res_o.error_code = out_err_q;
  assign res_o.read_data  = out_rx_q;

endmodule
